>>> design/tdp_pkg.sv
// Shared types and constants of the trial-division prime test.
// No dependencies; every other design file imports this package.
`default_nettype none

package tdp_pkg;

   localparam int NUM_WIDTH_DEF = 32;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LAUNCH,
      S_WAIT,
      S_REPLY
   } state_type;

endpackage

`default_nettype wire

>>> design/trial_division_prime_test_top.sv
// Top level of the trial-division prime test: control sequencer around tdp_div.
// Depends on tdp_pkg and tdp_div.
//
// Usage: drive req_number and raise start while busy is low; that edge takes
// the beat. busy stays high until the answer has been shown. The answer comes
// back as one beat: rsp_valid is high for exactly one cycle with rsp_is_prime
// beside it, and the receiver cannot hold it off.
// Negative numbers, zero and one go straight to the reply state. Otherwise
// divisors 2, 3, ... are tried in turn; each trial launches the bit-serial
// divider from the launch state, waits in the wait state for its done strobe
// and then decides. The search stops once the divisor exceeds the quotient
// (prime) or a remainder is zero (composite). Up to sqrt(number) trials are
// run, so the divider loop sets how long an item takes, and one item is in
// flight at a time. Synchronous reset returns the block to idle and drops
// any item in progress; no result is given for it.
`default_nettype none

module trial_division_prime_test_top import tdp_pkg::*; #(
   parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic signed [NUM_WIDTH-1:0] req_number,
   output logic                             rsp_valid,
   output logic                             rsp_is_prime
);

   state_type            state_ff, state_in;
   logic [NUM_WIDTH-1:0] num_ff;
   logic [NUM_WIDTH-1:0] d_ff;
   logic                 res_ff;
   logic                 accept;
   logic                 trivial;
   logic                 div_start;
   logic                 div_done;
   logic [NUM_WIDTH-1:0] div_quo;
   logic [NUM_WIDTH-1:0] div_rem;
   logic                 past_bound;

   assign accept     = start && !busy;
   // Negative, zero or one: never prime.
   assign trivial    = req_number[NUM_WIDTH-1] || (req_number[NUM_WIDTH-1:1] == '0);
   assign past_bound = d_ff > div_quo;

   tdp_div #(.NUM_WIDTH(NUM_WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (num_ff),
      .divisor   (d_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = trivial ? S_REPLY : S_LAUNCH;
            end
         end
         S_LAUNCH: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_done) begin
               state_in = (past_bound || (div_rem == '0)) ? S_REPLY : S_LAUNCH;
            end
         end
         S_REPLY: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         S_IDLE:   busy      = 1'b0;
         S_LAUNCH: div_start = 1'b1;
         S_WAIT:   busy      = 1'b1;
         S_REPLY:  rsp_valid = 1'b1;
         default:  busy      = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (accept) begin
         num_ff <= req_number;
         d_ff   <= NUM_WIDTH'(2);
         res_ff <= 1'b0;
      end else if (state_ff == S_WAIT && div_done) begin
         // The bound test comes first: a divisor past the square root ends the search.
         if (past_bound) begin
            res_ff <= 1'b1;
         end else if (div_rem == '0) begin
            res_ff <= 1'b0;
         end else begin
            d_ff <= d_ff + 1'b1;
         end
      end
   end

   assign rsp_is_prime = res_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy did not rise after an accepted beat");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_WAIT))
      else $error("divider finished outside the wait state");

   a_reply_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block not idle after a result beat");

   a_divisor_min: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |-> (d_ff >= NUM_WIDTH'(2)))
      else $error("trial divisor below two");

endmodule

`default_nettype wire

>>> design/tdp_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tdp_pkg for the default operand width.
`default_nettype none

module tdp_div import tdp_pkg::*; #(
   parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [NUM_WIDTH-1:0] dividend,
   input  wire logic [NUM_WIDTH-1:0] divisor,
   output logic                      done,
   output logic      [NUM_WIDTH-1:0] quotient,
   output logic      [NUM_WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(NUM_WIDTH);

   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NUM_WIDTH-1:0] rem_ff, rem_in;
   logic [NUM_WIDTH-1:0] dq_ff, dq_in;
   logic [NUM_WIDTH:0]   trial;
   logic                 qbit;

   // The dividend shifts out at the top while quotient bits shift in at the bottom.
   assign trial = {rem_ff, dq_ff[NUM_WIDTH-1]} - {1'b0, divisor};
   assign qbit  = ~trial[NUM_WIDTH];

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      dq_in     = dq_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CNT_W'(NUM_WIDTH - 1);
         rem_in    = '0;
         dq_in     = dividend;
      end else if (active_ff) begin
         rem_in = qbit ? trial[NUM_WIDTH-1:0] : {rem_ff[NUM_WIDTH-2:0], dq_ff[NUM_WIDTH-1]};
         dq_in  = {dq_ff[NUM_WIDTH-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
   end

   assign done      = done_ff;
   assign quotient  = dq_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire
